@@ rtl/heap_sorter_core_defines.svh @@
// Assertion macros used by the checker file of the heap sorter.
`ifndef HEAP_SORTER_CORE_DEFINES_SVH
`define HEAP_SORTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/hs_pkg.sv @@
// ----------------------------------------------------------------------------
// Heap sorter package
// Shared constants, types and sequencer states of the heap sorter.
// ----------------------------------------------------------------------------
package hs_pkg;

   localparam int DEPTH   = 64;
   localparam int VALUE_W = 32;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CHILD_W = ADDR_W + 2;

   typedef logic signed [VALUE_W-1:0] hs_value_type;

   typedef struct packed {
      logic swap;
      logic right;
   } hs_pick_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BNEXT,
      ST_XNEXT,
      ST_XA,
      ST_XB,
      ST_XC,
      ST_RDN,
      ST_RDL,
      ST_SL,
      ST_RDR,
      ST_CMP,
      ST_WRT,
      ST_OUT
   } hs_state_type;

endpackage

@@ rtl/hs_ram.sv @@
// ----------------------------------------------------------------------------
// Heap sorter RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/hs_pick.sv @@
// ----------------------------------------------------------------------------
// Heap sorter compare unit
// Picks the largest of a node and its children for one sift-down step.
// ----------------------------------------------------------------------------
module hs_pick (
   input  hs_pkg::hs_value_type node_value,
   input  hs_pkg::hs_value_type left_value,
   input  hs_pkg::hs_value_type right_value,
   input  logic                 right_ok,
   output hs_pkg::hs_pick_type  pick,
   output hs_pkg::hs_value_type top_value
);
   import hs_pkg::*;

   logic         left_gt;
   logic         right_gt;
   hs_value_type best;

   always_comb begin
      left_gt    = left_value > node_value;
      best       = left_gt ? left_value : node_value;
      right_gt   = right_ok && (right_value > best);
      pick.swap  = left_gt || right_gt;
      pick.right = right_gt;
      top_value  = right_gt ? right_value : best;
   end

endmodule

@@ rtl/heap_sorter_core.sv @@
// ----------------------------------------------------------------------------
// Heap sorter core
// Collects a set of signed values, heap sorts them in a RAM and returns them
// in ascending order.
// ----------------------------------------------------------------------------
//   Channel   Handshake             Payload
//   request   start / busy          req_value, req_last
//   response  rsp_strobe (no hold)  rsp_value_res, rsp_last_res, rsp_dropped
//
// A value that is not last is accepted and busy stays low.
// A last value starts the sort: the heap build and each extraction step run
// on one compare unit and one two-port RAM. Results then stream out one per
// cycle; busy falls with the last.
// Reset is synchronous and needs no clearing pass of the store.
// ----------------------------------------------------------------------------
module heap_sorter_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hs_pkg::hs_value_type req_value,
   input  logic                 req_last,
   output logic                 rsp_strobe,
   output hs_pkg::hs_value_type rsp_value_res,
   output logic                 rsp_last_res,
   output logic                 rsp_dropped
);
   import hs_pkg::*;

   hs_state_type        state_ff, state_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic                ovf_ff, ovf_in;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic [CNT_W-1:0]    size_ff, size_in;
   logic [ADDR_W-1:0]   node_ff, node_in;
   logic [ADDR_W-1:0]   top_ff, top_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   hs_value_type        nval_ff, nval_in;
   hs_value_type        lval_ff, lval_in;
   hs_value_type        tmp_ff, tmp_in;
   logic                build_ff, build_in;
   logic                strobe_ff, strobe_in;
   logic                last_ff, last_in;
   logic                drop_ff, drop_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [VALUE_W-1:0]  wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   logic [VALUE_W-1:0]  rd_data;

   logic [CNT_W-1:0]    km1;
   logic [CHILD_W-1:0]  lc;
   logic [CHILD_W-1:0]  rc;
   logic                lc_ok;
   logic                rc_ok;
   hs_state_type        done_state;
   hs_pick_type         pick;
   hs_value_type        top_value;

   hs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hs_pick u_pick (
      .node_value  (nval_ff),
      .left_value  (lval_ff),
      .right_value ($signed(rd_data)),
      .right_ok    (rc_ok),
      .pick        (pick),
      .top_value   (top_value)
   );

   always_comb begin
      km1        = k_ff - CNT_W'(1);
      lc         = {1'b0, node_ff, 1'b1};
      rc         = lc + CHILD_W'(1);
      lc_ok      = lc < CHILD_W'(size_ff);
      rc_ok      = rc < CHILD_W'(size_ff);
      done_state = build_ff ? ST_BNEXT : ST_XNEXT;
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      ovf_in    = ovf_ff;
      k_in      = k_ff;
      size_in   = size_ff;
      node_in   = node_ff;
      top_in    = top_ff;
      idx_in    = idx_ff;
      nval_in   = nval_ff;
      lval_in   = lval_ff;
      tmp_in    = tmp_ff;
      build_in  = build_ff;
      strobe_in = 1'b0;
      last_in   = last_ff;
      drop_in   = drop_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_addr   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (fill_ff < CNT_W'(DEPTH)) begin
                  wr_en   = 1'b1;
                  wr_addr = fill_ff[ADDR_W-1:0];
                  wr_data = req_value;
                  fill_in = fill_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  k_in     = fill_in >> 1;
                  build_in = 1'b1;
                  state_in = ST_BNEXT;
               end
            end
         end
         ST_BNEXT: begin
            if (k_ff == '0) begin
               k_in     = fill_ff;
               build_in = 1'b0;
               state_in = ST_XNEXT;
            end else begin
               k_in     = km1;
               node_in  = km1[ADDR_W-1:0];
               size_in  = fill_ff;
               state_in = ST_RDN;
            end
         end
         ST_XNEXT: begin
            if (k_ff <= CNT_W'(1)) begin
               idx_in   = '0;
               state_in = ST_OUT;
            end else begin
               rd_addr  = '0;
               state_in = ST_XA;
            end
         end
         ST_XA: begin
            tmp_in   = $signed(rd_data);
            rd_addr  = km1[ADDR_W-1:0];
            state_in = ST_XB;
         end
         ST_XB: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = rd_data;
            nval_in  = $signed(rd_data);
            state_in = ST_XC;
         end
         ST_XC: begin
            wr_en    = 1'b1;
            wr_addr  = km1[ADDR_W-1:0];
            wr_data  = tmp_ff;
            size_in  = km1;
            k_in     = km1;
            node_in  = '0;
            state_in = ST_SL;
         end
         ST_RDN: begin
            rd_addr  = node_ff;
            state_in = ST_RDL;
         end
         ST_RDL, ST_SL: begin
            if (state_ff == ST_RDL) begin
               nval_in = $signed(rd_data);
            end
            if (lc_ok) begin
               rd_addr  = lc[ADDR_W-1:0];
               state_in = ST_RDR;
            end else begin
               state_in = done_state;
            end
         end
         ST_RDR: begin
            lval_in  = $signed(rd_data);
            rd_addr  = rc[ADDR_W-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (pick.swap) begin
               wr_en    = 1'b1;
               wr_addr  = node_ff;
               wr_data  = top_value;
               top_in   = pick.right ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
               state_in = ST_WRT;
            end else begin
               state_in = done_state;
            end
         end
         ST_WRT: begin
            wr_en    = 1'b1;
            wr_addr  = top_ff;
            wr_data  = nval_ff;
            node_in  = top_ff;
            state_in = ST_SL;
         end
         ST_OUT: begin
            rd_addr   = idx_ff;
            strobe_in = 1'b1;
            drop_in   = ovf_ff;
            last_in   = CNT_W'(idx_ff) == (fill_ff - CNT_W'(1));
            if (last_in) begin
               fill_in  = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         ovf_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         ovf_ff    <= ovf_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      size_ff  <= size_in;
      node_ff  <= node_in;
      top_ff   <= top_in;
      idx_ff   <= idx_in;
      nval_ff  <= nval_in;
      lval_ff  <= lval_in;
      tmp_ff   <= tmp_in;
      build_ff <= build_in;
      last_ff  <= last_in;
      drop_ff  <= drop_in;
   end

   assign busy          = state_ff != ST_IDLE;
   assign rsp_strobe    = strobe_ff;
   assign rsp_value_res = $signed(rd_data);
   assign rsp_last_res  = last_ff;
   assign rsp_dropped   = drop_ff;

endmodule

@@ rtl/hs_checker.sv @@
// ----------------------------------------------------------------------------
// Heap sorter checker
// Port-level assertions on the heap sorter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "heap_sorter_core_defines.svh"

module hs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last,
   input logic rsp_strobe,
   input logic rsp_last_res
);

   // A final value must start the sort, and other values must not.
   `HS_ASSERT_NEXT(a_last_starts_sort, clock, reset, start && !busy && req_last, busy, "sort did not start after final value")
   `HS_ASSERT_NEXT(a_load_stays_ready, clock, reset, start && !busy && !req_last, !busy, "block went busy on a non-final value")

   // Results of one set come in an unbroken burst that ends with the final one.
   `HS_ASSERT_NEXT(a_burst_contiguous, clock, reset, rsp_strobe && !rsp_last_res, rsp_strobe, "gap inside a result burst")
   `HS_ASSERT_NEXT(a_burst_ends, clock, reset, rsp_strobe && rsp_last_res, !rsp_strobe, "result after the final transaction")
   `HS_ASSERT_SAME(a_burst_busy, clock, reset, rsp_strobe && !rsp_last_res, busy, "block ready in the middle of a burst")

endmodule

bind heap_sorter_core hs_checker u_hs_checker (.*);

@@ test/heap_sorter_core_tb.sv @@
// ----------------------------------------------------------------------------
// Heap sorter core testbench
// Sends sets of signed values to the core over the start/busy handshake and
// keeps a running prediction of each set in ascending order. Every result
// transaction is checked for value, last and dropped flags against that
// prediction. The stimulus covers extreme values, duplicates, one-value sets,
// sets that fill the store exactly, and sets that overflow it.
// ----------------------------------------------------------------------------
module heap_sorter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hs_pkg::*;

   localparam int RUN_ITEMS   = 380;
   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_GAP     = 13;
   localparam int TAIL_CYCLES = 64;
   localparam int PRINT_LIMIT = 40;

   typedef enum int {
      FILL_WIDE,
      FILL_NARROW,
      FILL_EDGE
   } fill_kind_type;

   typedef struct {
      hs_value_type value;
      logic         last;
      logic         dropped;
   } sorted_word_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         start     = 1'b0;
   logic         busy;
   hs_value_type req_value = '0;
   logic         req_last  = 1'b0;
   logic         rsp_strobe;
   hs_value_type rsp_value_res;
   logic         rsp_last_res;
   logic         rsp_dropped;

   hs_value_type    ranked_values[$];
   logic            set_overflowed = 1'b0;
   sorted_word_type sorted_expect[$];

   int gap_ceiling = MAX_GAP;
   int items_sent;
   int sets_sorted;
   int overflow_sets;
   int results_checked;
   int mismatches;
   int cycle_count;

   heap_sorter_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_strobe    (rsp_strobe),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_dropped   (rsp_dropped)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, sorted_expect.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
   endtask

   // Keeps the values of the open set in ascending order as they arrive, so a
   // last transaction only has to release the ranked list.
   task automatic predict_sorted_set(input hs_value_type v, input logic lst);
      int              idx;
      sorted_word_type word;
      if (ranked_values.size() < DEPTH) begin
         idx = 0;
         while (idx < ranked_values.size() && ranked_values[idx] <= v) begin
            idx++;
         end
         ranked_values.insert(idx, v);
      end else begin
         set_overflowed = 1'b1;
      end
      if (lst) begin
         foreach (ranked_values[k]) begin
            word.value   = ranked_values[k];
            word.last    = (k == ranked_values.size() - 1);
            word.dropped = set_overflowed;
            sorted_expect.push_back(word);
         end
         sets_sorted++;
         if (set_overflowed) begin
            overflow_sets++;
         end
         ranked_values.delete();
         set_overflowed = 1'b0;
      end
   endtask

   always @(posedge clock) begin : check_results
      sorted_word_type want;
      if (!reset && rsp_strobe) begin
         if (sorted_expect.size() == 0) begin
            report_mismatch($sformatf("unexpected result transaction, value %0d",
                                      rsp_value_res));
         end else begin
            want = sorted_expect.pop_front();
            results_checked++;
            if (rsp_value_res !== want.value) begin
               report_mismatch($sformatf("value %0d, expected %0d",
                                         rsp_value_res, want.value));
            end
            if (rsp_last_res !== want.last) begin
               report_mismatch($sformatf("last flag %b, expected %b",
                                         rsp_last_res, want.last));
            end
            if (rsp_dropped !== want.dropped) begin
               report_mismatch($sformatf("dropped flag %b, expected %b",
                                         rsp_dropped, want.dropped));
            end
         end
      end
   end

   // Start stays high between back-to-back transactions; it is lowered
   // when a gap is drawn and by hold_until_drained.
   task automatic send_value(input hs_value_type v, input logic lst);
      int gap;
      gap = $urandom_range(0, gap_ceiling);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= v;
      req_last  <= lst;
      do @(posedge clock); while (busy);
      predict_sorted_set(v, lst);
      items_sent++;
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sorted_expect.size() != 0) @(posedge clock);
   endtask

   function automatic hs_value_type draw_value(input fill_kind_type kind);
      case (kind)
         FILL_NARROW: return hs_value_type'(int'($urandom_range(0, 8)) - 4);
         FILL_EDGE: begin
            case ($urandom_range(0, 5))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               4: return 32'h7FFF_FFFE;
               default: return 32'h8000_0001;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_set(input int count, input fill_kind_type kind);
      for (int k = 0; k < count; k++) begin
         send_value(draw_value(kind), k == count - 1);
      end
   endtask

   task automatic test_directed();
      gap_ceiling = MAX_GAP;
      send_value(32'h8000_0000, 1'b1);
      send_value(32'h7FFF_FFFF, 1'b1);
      send_value(32'h7FFF_FFFF, 1'b0);
      send_value(32'h8000_0000, 1'b0);
      send_value(32'h0000_0000, 1'b0);
      send_value(32'hFFFF_FFFF, 1'b0);
      send_value(32'h0000_0001, 1'b0);
      send_value(32'h7FFF_FFFF, 1'b0);
      send_value(32'h8000_0000, 1'b0);
      send_value(32'hAAAA_5555, 1'b1);
      send_value(32'h0000_0007, 1'b0);
      send_value(32'h0000_0007, 1'b1);
      send_value(32'h0000_0003, 1'b0);
      send_value(32'hFFFF_FFFD, 1'b1);
      hold_until_drained();
   endtask

   task automatic test_store_capacity();
      gap_ceiling = 0;
      send_random_set(DEPTH, FILL_WIDE);
      hold_until_drained();
      gap_ceiling = MAX_GAP;
      send_random_set(DEPTH + 2, FILL_NARROW);
      hold_until_drained();
   endtask

   task automatic test_random_sets();
      int            count;
      fill_kind_type kind;
      while (items_sent < RUN_ITEMS) begin
         gap_ceiling = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
         kind = fill_kind_type'($urandom_range(0, 2));
         if ($urandom_range(0, 19) == 0) begin
            count = $urandom_range(DEPTH - 2, DEPTH + 4);
         end else begin
            count = $urandom_range(1, 12);
         end
         send_random_set(count, kind);
         if ($urandom_range(0, 7) == 0) begin
            hold_until_drained();
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_store_capacity();
      test_random_sets();
      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("sent %0d values in %0d sets (%0d overflowed), checked %0d results",
               items_sent, sets_sorted, overflow_sets, results_checked);
      $display("%0d mismatches in %0d cycles", mismatches, cycle_count);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
